[design/singleton_value_tracker_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the singleton value tracker
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef SINGLETON_VALUE_TRACKER_DEFINES_SVH
`define SINGLETON_VALUE_TRACKER_DEFINES_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define SVT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the following cycle, disabled while reset is asserted.
`define SVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/svt_pkg.sv]
// ----------------------------------------------------------------------------
// Singleton value tracker package
// Field widths, status codes and the update record of the count unit.
// ----------------------------------------------------------------------------
package svt_pkg;

	localparam int unsigned VALUE_W   = 10;
	localparam int unsigned TOTAL_W   = 11;
	localparam int unsigned STATUS_W  = 2;
	// Number of distinct codes the value field can carry.
	localparam int unsigned NUM_CODES = 1 << VALUE_W;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_ABSENT   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// What the count unit decides for one beat.
	typedef struct packed {
		logic    wr;     // count changes and is written back
		logic    push;   // value becomes a singleton
		logic    drop;   // value stops being a singleton
		status_t status;
	} cnt_upd_t;

endpackage

[design/singleton_value_tracker.sv]
// ----------------------------------------------------------------------------
// Singleton value tracker
// Path: an accepted beat passes CNT, then DROP and TOP when a value leaves
// the singleton set, then OUT, which hands the result to the output register.
// Beats are taken one at a time, only in IDLE, as the read-modify-write chain
// runs through the count, slot and stack memories under one sequencer.
// Reset: a clearing pass over min(NUM_VALUES, 1024) entries zeroes the count
// memory; no input beat is taken until it ends.
// ----------------------------------------------------------------------------
module singleton_value_tracker #(
	parameter int unsigned NUM_VALUES = 1024,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [svt_pkg::VALUE_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          has_singleton,
	output logic [svt_pkg::VALUE_W-1:0]   singleton_value,
	output logic [svt_pkg::TOTAL_W-1:0]   singleton_total,
	output logic [svt_pkg::STATUS_W-1:0]  status
);

	// Only values that the value field can carry ever reach the tables, so the
	// memories are no deeper than the smaller of the two ranges.
	localparam int unsigned DEPTH = (NUM_VALUES < svt_pkg::NUM_CODES) ?
		NUM_VALUES : svt_pkg::NUM_CODES;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned HGT_W = $clog2(DEPTH + 1);

	// The sequencer. CLEAR sweeps the count memory after reset. CNT sees the
	// count read issued on acceptance and decides the update. DROP performs the
	// swap-removal, and TOP recovers the new top of the stack. OUT hands the
	// result to the output register.
	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_CNT   = 6'b000100,
		S_DROP  = 6'b001000,
		S_TOP   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [IDX_W-1:0]              clr_idx_q;
	logic [HGT_W-1:0]              height_q;
	logic                          out_valid_q;

	logic                          action_q;
	logic [svt_pkg::VALUE_W-1:0]   value_q;
	svt_pkg::status_t              status_q;
	logic [svt_pkg::VALUE_W-1:0]   top_q;
	logic [IDX_W-1:0]              slot_q;
	logic [svt_pkg::VALUE_W-1:0]   moved_q;

	logic                          has_q;
	logic [svt_pkg::VALUE_W-1:0]   sval_q;
	logic [svt_pkg::TOTAL_W-1:0]   total_q;
	logic [svt_pkg::STATUS_W-1:0]  stat_q;

	logic                          in_fire;
	logic                          load_out;
	logic                          in_range;
	logic [IDX_W-1:0]              vidx;

	logic                          cnt_we;
	logic [IDX_W-1:0]              cnt_waddr;
	logic [COUNT_BITS-1:0]         cnt_wdata;
	logic [COUNT_BITS-1:0]         cnt_rd;
	logic [COUNT_BITS-1:0]         cnt_next;
	svt_pkg::cnt_upd_t             upd;

	logic                          stk_we;
	logic [IDX_W-1:0]              stk_waddr;
	logic [svt_pkg::VALUE_W-1:0]   stk_wdata;
	logic                          stk_re;
	logic [IDX_W-1:0]              stk_raddr;
	logic [svt_pkg::VALUE_W-1:0]   stk_rd;

	logic                          slt_we;
	logic [IDX_W-1:0]              slt_waddr;
	logic [IDX_W-1:0]              slt_wdata;
	logic                          slt_re;
	logic [IDX_W-1:0]              slt_rd;

	// Input is taken only when the engine is idle; the output register lets the
	// next beat in while an earlier result still waits downstream.
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign in_range = (32'(value_q) < NUM_VALUES);
	assign vidx     = value_q[IDX_W-1:0];

	svt_count_unit #(
		.COUNT_BITS (COUNT_BITS)
	) u_cnt_unit (
		.action     (action_q),
		.in_range   (in_range),
		.count      (cnt_rd),
		.count_next (cnt_next),
		.upd        (upd)
	);

	// Count memory: cleared by the sweep, written back in CNT, read on accept.
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = vidx;
		cnt_wdata = cnt_next;
		if (state_q == S_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_idx_q;
			cnt_wdata = '0;
		end else if (state_q == S_CNT) begin
			cnt_we = upd.wr;
		end
	end

	svt_ram #(
		.DEPTH (DEPTH),
		.WIDTH (COUNT_BITS)
	) u_cnt_mem (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (in_fire),
		.raddr (value[IDX_W-1:0]),
		.rdata (cnt_rd)
	);

	// Stack memory. A push writes the value at the current height. On a drop,
	// CNT reads the old top; DROP moves it into the vacated slot and reads the
	// entry just below it, which becomes the top unless the move landed there.
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = height_q[IDX_W-1:0];
		stk_wdata = value_q;
		stk_re    = 1'b0;
		stk_raddr = IDX_W'(height_q - HGT_W'(1));
		if (state_q == S_CNT) begin
			stk_we = upd.push;
			stk_re = upd.drop;
		end else if (state_q == S_DROP) begin
			stk_we    = 1'b1;
			stk_waddr = slt_rd;
			stk_wdata = stk_rd;
			stk_re    = 1'b1;
			stk_raddr = IDX_W'(height_q - HGT_W'(2));
		end
	end

	svt_ram #(
		.DEPTH (DEPTH),
		.WIDTH (svt_pkg::VALUE_W)
	) u_stk_mem (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	// Slot memory: where each singleton sits in the stack.
	always_comb begin
		slt_we    = 1'b0;
		slt_waddr = vidx;
		slt_wdata = height_q[IDX_W-1:0];
		slt_re    = 1'b0;
		if (state_q == S_CNT) begin
			slt_we = upd.push;
			slt_re = upd.drop;
		end else if (state_q == S_DROP) begin
			slt_we    = 1'b1;
			slt_waddr = stk_rd[IDX_W-1:0];
			slt_wdata = slt_rd;
		end
	end

	svt_ram #(
		.DEPTH (DEPTH),
		.WIDTH (IDX_W)
	) u_slt_mem (
		.clk   (clk),
		.we    (slt_we),
		.waddr (slt_waddr),
		.wdata (slt_wdata),
		.re    (slt_re),
		.raddr (vidx),
		.rdata (slt_rd)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_idx_q <= '0;
			height_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					if (upd.push) begin
						height_q <= height_q + HGT_W'(1);
						state_q  <= S_OUT;
					end else if (upd.drop) begin
						state_q <= S_DROP;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DROP: begin
					height_q <= height_q - HGT_W'(1);
					state_q  <= S_TOP;
				end
				S_TOP: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Working registers of the current beat; no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q <= action;
			value_q  <= value;
		end
		if (state_q == S_CNT) begin
			status_q <= upd.status;
			if (upd.push) begin
				top_q <= value_q;
			end
		end
		if (state_q == S_DROP) begin
			slot_q  <= slt_rd;
			moved_q <= stk_rd;
		end
		// The height has already shrunk here, so height - 1 is the new top slot.
		if (state_q == S_TOP) begin
			top_q <= (slot_q == IDX_W'(height_q - HGT_W'(1))) ? moved_q : stk_rd;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			has_q   <= (height_q != '0);
			sval_q  <= (height_q != '0) ? top_q : '0;
			total_q <= svt_pkg::TOTAL_W'(height_q);
			stat_q  <= status_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign has_singleton   = has_q;
	assign singleton_value = sval_q;
	assign singleton_total = total_q;
	assign status          = stat_q;

endmodule

[design/svt_ram.sv]
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module svt_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/svt_count_unit.sv]
// ----------------------------------------------------------------------------
// Occurrence count update unit
// Steps a count up or down by one and classifies the singleton transition.
// ----------------------------------------------------------------------------
module svt_count_unit #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                  action,
	input  logic                  in_range,
	input  logic [COUNT_BITS-1:0] count,
	output logic [COUNT_BITS-1:0] count_next,
	output svt_pkg::cnt_upd_t     upd
);

	always_comb begin
		count_next = count;
		upd.wr     = 1'b0;
		upd.push   = 1'b0;
		upd.drop   = 1'b0;
		upd.status = svt_pkg::ST_OK;
		priority if (!in_range) begin
			upd.status = action ? svt_pkg::ST_ABSENT : svt_pkg::ST_OVERFLOW;
		end else if (!action) begin
			if (count == '1) begin
				upd.status = svt_pkg::ST_OVERFLOW;
			end else begin
				count_next = count + COUNT_BITS'(1);
				upd.wr     = 1'b1;
				upd.push   = (count == '0);
				upd.drop   = (count == COUNT_BITS'(1));
			end
		end else begin
			if (count == '0) begin
				upd.status = svt_pkg::ST_ABSENT;
			end else begin
				count_next = count - COUNT_BITS'(1);
				upd.wr     = 1'b1;
				upd.push   = (count == COUNT_BITS'(2));
				upd.drop   = (count == COUNT_BITS'(1));
			end
		end
	end

endmodule

[design/svt_checker.sv]
// ----------------------------------------------------------------------------
// Singleton value tracker port checker
// Watches the result channel for consistency of the reported fields.
// ----------------------------------------------------------------------------
`include "singleton_value_tracker_defines.svh"

module svt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          has_singleton,
	input logic [svt_pkg::VALUE_W-1:0]   singleton_value,
	input logic [svt_pkg::TOTAL_W-1:0]   singleton_total,
	input logic [svt_pkg::STATUS_W-1:0]  status
);

	`SVT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(singleton_total) && $stable(singleton_value) && $stable(status), "stalled result beat changed")
	`SVT_ASSERT_SAME(a_has_total, clk, arst_n, out_valid, has_singleton == (singleton_total != '0), "has_singleton disagrees with singleton_total")
	`SVT_ASSERT_SAME(a_empty_value, clk, arst_n, out_valid && !has_singleton, singleton_value == '0, "singleton_value not zero with an empty set")
	`SVT_ASSERT_SAME(a_status_code, clk, arst_n, out_valid, status == svt_pkg::ST_OK || status == svt_pkg::ST_ABSENT || status == svt_pkg::ST_OVERFLOW, "undefined status code")

endmodule

bind singleton_value_tracker svt_checker u_svt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.has_singleton   (has_singleton),
	.singleton_value (singleton_value),
	.singleton_total (singleton_total),
	.status          (status)
);

[tb/sv/singleton_value_tracker_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Singleton value tracker checker
// Watches both channels. It keeps its own copy of the count, stack and slot
// tables and predicts every result beat. Each result beat is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module singleton_value_tracker_checker
	import svt_pkg::*;
#(
	parameter int unsigned NUM_VALUES = 1024,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 action,
	input  logic [VALUE_W-1:0]   value,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 has_singleton,
	input  logic [VALUE_W-1:0]   singleton_value,
	input  logic [TOTAL_W-1:0]   singleton_total,
	input  logic [STATUS_W-1:0]  status,
	output int                   fail_count,
	output int                   outstanding
);

	typedef struct packed {
		logic               has;
		logic [VALUE_W-1:0] top;
		logic [TOTAL_W-1:0] total;
		status_t            st;
	} singleton_view_t;

	logic [COUNT_BITS-1:0] occ_count  [NUM_VALUES];
	int unsigned           stack_vals [NUM_VALUES];
	int unsigned           slot_of    [NUM_VALUES];
	int unsigned           height;

	singleton_view_t awaited_views[$];
	int              errs;

	function automatic void push_singleton(input int unsigned v);
		if (height < NUM_VALUES) begin
			stack_vals[height] = v;
			slot_of[v] = height;
			height++;
		end
	endfunction

	// Swap-removal: the top entry fills the hole left by v.
	function automatic void drop_singleton(input int unsigned v);
		int unsigned hole;
		int unsigned moved;
		if (height != 0) begin
			hole = slot_of[v];
			moved = stack_vals[height - 1];
			stack_vals[hole] = moved;
			slot_of[moved] = hole;
			height--;
		end
	endfunction

	function automatic singleton_view_t update_singletons(input logic is_removal,
			input logic [VALUE_W-1:0] val);
		singleton_view_t       view;
		logic [COUNT_BITS-1:0] cnt;
		view.st = ST_OK;
		if (val >= NUM_VALUES) begin
			view.st = is_removal ? ST_ABSENT : ST_OVERFLOW;
		end else begin
			cnt = occ_count[val];
			if (!is_removal) begin
				if (&cnt) begin
					view.st = ST_OVERFLOW;
				end else begin
					cnt = cnt + COUNT_BITS'(1);
					occ_count[val] = cnt;
					if (cnt == 1)
						push_singleton(32'(val));
					else if (cnt == 2)
						drop_singleton(32'(val));
				end
			end else begin
				if (cnt == 0) begin
					view.st = ST_ABSENT;
				end else begin
					cnt = cnt - COUNT_BITS'(1);
					occ_count[val] = cnt;
					if (cnt == 1)
						push_singleton(32'(val));
					else if (cnt == 0)
						drop_singleton(32'(val));
				end
			end
		end
		view.has = (height != 0);
		view.top = (height != 0) ? VALUE_W'(stack_vals[height - 1]) : '0;
		view.total = TOTAL_W'(height);
		return view;
	endfunction

	function automatic int field_check(input string name, input logic [TOTAL_W-1:0] want,
			input logic [TOTAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		singleton_view_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_VALUES; i++) begin
				occ_count[i] = '0;
				stack_vals[i] = 0;
				slot_of[i] = 0;
			end
			height = 0;
			awaited_views.delete();
			errs = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// Results are checked before the input of the same edge is applied;
			// the block never answers in the cycle that it takes a beat.
			if (out_valid && out_ready) begin
				if (awaited_views.size() == 0) begin
					$display("%0t: result beat with none expected, actual total %0d status %0d",
						$time, singleton_total, status);
					errs++;
				end else begin
					want = awaited_views.pop_front();
					errs += field_check("has_singleton", TOTAL_W'(want.has),
						TOTAL_W'(has_singleton));
					errs += field_check("singleton_value", TOTAL_W'(want.top),
						TOTAL_W'(singleton_value));
					errs += field_check("singleton_total", want.total, singleton_total);
					errs += field_check("status", TOTAL_W'(want.st), TOTAL_W'(status));
				end
			end
			if (in_valid && in_ready)
				awaited_views.push_back(update_singletons(action, value));
			fail_count <= errs;
			outstanding <= awaited_views.size();
		end
	end

endmodule

[tb/sv/singleton_value_tracker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Singleton value tracker testbench
// Drives add and remove beats into the tracker: a directed opening, a pass
// that makes every value a singleton, and a random mix. A separate checker
// predicts and compares results.
// ----------------------------------------------------------------------------
module singleton_value_tracker_tb;
	import svt_pkg::*;

	localparam int unsigned NUM_VALUES = 1024;
	localparam int unsigned COUNT_BITS = 16;
	localparam int          CLK_PERIOD = 4;

	// Action codes on the input channel.
	localparam logic ADD    = 1'b0;
	localparam logic REMOVE = 1'b1;

	localparam int RANDOM_BEATS = 260;
	// The tail of the random part runs with no idling on either side.
	localparam int CALM_BEATS   = 60;
	localparam int POOL_SIZE    = 16;
	localparam int HOLD_CYCLES  = 400;
	// The slowest result passes CNT, DROP, TOP and OUT; allow a good margin.
	localparam int DRAIN_CYCLES = 20;
	// About 1.3k beats in all. Each can see a random input gap and a random
	// output stall on top of its own processing. With the clearing pass and
	// the long hold-off added, the limit is several times the total.
	localparam int CYCLE_LIMIT  = 200_000;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                in_valid        = 1'b0;
	logic                in_ready;
	logic                action          = ADD;
	logic [VALUE_W-1:0]  value           = '0;
	logic                out_valid;
	logic                out_ready       = 1'b0;
	logic                has_singleton;
	logic [VALUE_W-1:0]  singleton_value;
	logic [TOTAL_W-1:0]  singleton_total;
	logic [STATUS_W-1:0] status;

	int  fail_count;
	int  outstanding;
	int  cycle_count     = 0;
	// Written only by the stimulus process, with nonblocking assignments, and
	// read by the receiver at clock edges.
	logic idling         = 1'b1;
	int   pressure_pulses = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	singleton_value_tracker #(
		.NUM_VALUES (NUM_VALUES),
		.COUNT_BITS (COUNT_BITS)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.value           (value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.has_singleton   (has_singleton),
		.singleton_value (singleton_value),
		.singleton_total (singleton_total),
		.status          (status)
	);

	singleton_value_tracker_checker #(
		.NUM_VALUES (NUM_VALUES),
		.COUNT_BITS (COUNT_BITS)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.value           (value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.has_singleton   (has_singleton),
		.singleton_value (singleton_value),
		.singleton_total (singleton_total),
		.status          (status),
		.fail_count      (fail_count),
		.outstanding     (outstanding)
	);

	// Watchdog. A hung handshake or a result that never comes ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver. Normally ready, with random stall bursts while idling is on.
	// When the stimulus asks for pressure, ready stays low for a long stretch
	// so that the block backs up and drops in_ready while beats keep coming.
	initial begin
		int pressure_seen;
		pressure_seen = 0;
		forever begin
			@(posedge clk);
			if (pressure_pulses != pressure_seen) begin
				pressure_seen = pressure_pulses;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offers one beat and returns at the edge where it is taken. Valid is left
	// high so that a following beat goes out back to back; only a gap lowers it.
	task automatic send_beat(input logic act, input logic [VALUE_W-1:0] val);
		int gap;
		if (idling && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		value <= val;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	initial begin
		logic [VALUE_W-1:0] order [NUM_VALUES];
		logic [VALUE_W-1:0] pool [POOL_SIZE];
		logic [VALUE_W-1:0] swap_tmp;
		logic [VALUE_W-1:0] pick;
		int unsigned        j;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening. Both ends of the value range, swap-removal of the
		// bottom entry, removal of an absent value, and a count walking up to
		// three and back so that the value leaves and rejoins the set.
		send_beat(ADD, 10'd0);
		send_beat(ADD, 10'd1023);
		send_beat(REMOVE, 10'd0);
		send_beat(REMOVE, 10'd0);
		send_beat(REMOVE, 10'd1023);
		send_beat(REMOVE, 10'd1023);
		send_beat(ADD, 10'd5);
		send_beat(ADD, 10'd5);
		send_beat(ADD, 10'd5);
		send_beat(REMOVE, 10'd5);
		send_beat(REMOVE, 10'd5);
		send_beat(REMOVE, 10'd5);
		// Four singletons, then drops from the middle and from the top.
		send_beat(ADD, 10'd7);
		send_beat(ADD, 10'd9);
		send_beat(ADD, 10'd11);
		send_beat(ADD, 10'd13);
		send_beat(REMOVE, 10'd9);
		send_beat(ADD, 10'd11);
		send_beat(REMOVE, 10'd13);
		send_beat(REMOVE, 10'd7);
		send_beat(REMOVE, 10'd11);
		send_beat(REMOVE, 10'd11);

		// Every value once, in shuffled order: the set grows to its full size.
		for (int i = 0; i < NUM_VALUES; i++)
			order[i] = VALUE_W'(i);
		for (int i = NUM_VALUES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap_tmp = order[i];
			order[i] = order[j];
			order[j] = swap_tmp;
		end
		for (int i = 0; i < NUM_VALUES; i++)
			send_beat(ADD, order[i]);

		// Random part. Most beats hit a small pool so counts hover around one
		// and the stack sees many pushes and swap-removals; the rest spread
		// over the whole range. It opens with the long output hold-off.
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			pool[i] = VALUE_W'($urandom_range(0, NUM_VALUES - 1));
		pressure_pulses <= pressure_pulses + 1;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n == RANDOM_BEATS - CALM_BEATS)
				idling <= 1'b0;
			if ($urandom_range(0, 9) < 7)
				pick = pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				pick = VALUE_W'($urandom);
			send_beat($urandom_range(0, 1) ? REMOVE : ADD, pick);
		end
		in_valid <= 1'b0;

		// Wait for every predicted result, then give stray beats time to show.
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/svt_pkg.sv
design/svt_ram.sv
design/svt_count_unit.sv
design/singleton_value_tracker.sv
design/svt_checker.sv
tb/sv/singleton_value_tracker_checker.sv
tb/sv/singleton_value_tracker_tb.sv
